// File: hdl/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

    // Field and datapath widths
    localparam int LP_W   = 22;                  // low-pass output, wraps
    localparam int HP_W   = 28;                  // high-pass output, Q.5, wraps
    localparam int DV_W   = 31;                  // derivative, exact
    localparam int MAG_W  = 30;                  // derivative magnitude
    localparam int VAL_W  = 48;                  // squared, integrator, levels
    localparam int CFG_W  = 48;                  // configuration data

    // Filter taps
    localparam int LP_DEPTH    = 12;
    localparam int LP_TAP_MID  = 5;
    localparam int HP_DEPTH    = 33;
    localparam int HP_TAP_A    = 15;
    localparam int HP_TAP_B    = 16;
    localparam int HP_FRAC     = 5;
    localparam int DV_DEPTH    = 4;

    // Square and window
    localparam int SQ_SHIFT      = 8;
    localparam int WINDOW_TAPS   = 30;
    localparam int SQ_LINE_DEPTH = WINDOW_TAPS - 1;
    localparam int INT_SHIFT     = 5;
    // 30 values below 2^48 stay below 2^53, so the window sum fits this width
    // and the scaled output fits VAL_W without saturation
    localparam int WIN_W         = VAL_W + INT_SHIFT;

    // Peak averaging
    localparam int PEAK_AVG_DEPTH = 8;
    localparam int AVG_SHIFT      = $clog2(PEAK_AVG_DEPTH);
    localparam int PSUM_W         = VAL_W + AVG_SHIFT;
    localparam int THR_W          = VAL_W + 3;

    // Pipeline: input, low-pass, high-pass, derivative, square, window, output
    localparam int NSTAGE = 7;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_INIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LEVEL_INIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL_INIT  = 2'd2;

    typedef struct packed {
        logic lp;
        logic hp;
    } t_filt_ld;

    typedef struct packed {
        logic dv;
        logic sq;
        logic integ;
    } t_energy_ld;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

endpackage

`default_nettype wire

// File: hdl/qrs_detector.sv
// QRS detector for ECG samples.
// Input channel: one converter sample per request (i_valid / o_stall). A
// request is taken at a rising edge with i_valid high and o_stall low.
// Output channel: one result per sample (o_valid / i_stall) carrying the
// band-pass value (Q.5), the window integrator value (Q.8) and the
// detection flag. A result is taken at an edge with o_valid high and
// i_stall low.
// Configuration: i_cfg_we writes i_cfg_data into the register chosen by
// i_cfg_idx (threshold, signal level, noise level start values); unused
// indexes are dropped. Write only while no sample is in flight.
// Throughput: one sample per cycle while the receiver does not stall, set
// by the seven-register pipeline (input, low-pass, high-pass, derivative,
// square, window, output), through which each sample reaches the outputs.
// Reset clears all filter lines, the peak tracker, both peak stores and
// the levels and threshold. When the receiver stalls, the result holds
// and the pipeline keeps filling its empty stages before raising o_stall.
`default_nettype none

module qrs_detector #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [SAMPLE_BITS-1:0]         i_sample,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [qrs_pkg::HP_W-1:0]     o_bandpass_value,
    output logic [qrs_pkg::VAL_W-1:0]           o_integrated_value,
    output logic                                o_qrs_flag,
    input  wire logic                           i_cfg_we,
    input  wire logic [qrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [qrs_pkg::CFG_W-1:0]      i_cfg_data
);
    import qrs_pkg::*;

    logic [NSTAGE-1:0]      r_vld;
    logic [NSTAGE-1:0]      w_rdy;
    logic [NSTAGE-1:0]      w_ld;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [HP_W-1:0]        w_hp;
    logic [HP_W-1:0]        w_bp_int;
    logic [VAL_W-1:0]       w_cur;
    logic [HP_W-1:0]        w_bp_out;
    t_filt_ld               w_filt_ld;
    t_energy_ld             w_energy_ld;
    t_cfg_wr                w_cfg;

    // A stage can take a request when it is empty or its item moves on.
    always_comb begin
        w_rdy[NSTAGE-1] = !r_vld[NSTAGE-1] || !i_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        w_ld[0] = i_valid && w_rdy[0];
        for (int k = 1; k < NSTAGE; k++)
            w_ld[k] = r_vld[k-1] && w_rdy[k];
    end

    // Advance valid bits: a ready stage takes whatever arrives, else hold.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTAGE; k++)
                if (w_rdy[k]) r_vld[k] <= w_ld[k];
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) r_sample <= i_sample;
    end

    assign w_filt_ld   = '{lp: w_ld[1], hp: w_ld[2]};
    assign w_energy_ld = '{dv: w_ld[3], sq: w_ld[4], integ: w_ld[5]};
    assign w_cfg       = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    qrs_filter #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ld     (w_filt_ld),
        .i_sample (r_sample),
        .o_hp     (w_hp)
    );

    qrs_energy u_energy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_energy_ld),
        .i_hp    (w_hp),
        .o_bp    (w_bp_int),
        .o_cur   (w_cur)
    );

    qrs_threshold u_threshold (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ld         (w_ld[NSTAGE-1]),
        .i_cfg        (w_cfg),
        .i_cur        (w_cur),
        .i_bp         (w_bp_int),
        .o_bp         (w_bp_out),
        .o_integrated (o_integrated_value),
        .o_qrs        (o_qrs_flag)
    );

    assign o_bandpass_value = $signed(w_bp_out);
    assign o_valid          = r_vld[NSTAGE-1];
    assign o_stall          = !w_rdy[0];

endmodule

`default_nettype wire

// File: hdl/qrs_filter.sv
`default_nettype none

module qrs_filter #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire qrs_pkg::t_filt_ld        i_ld,
    input  wire logic [SAMPLE_BITS-1:0]   i_sample,
    output logic [qrs_pkg::HP_W-1:0]      o_hp
);
    import qrs_pkg::*;

    logic [SAMPLE_BITS-1:0] r_lp_x [LP_DEPTH];
    logic [LP_W-1:0]        r_lp_y0;
    logic [LP_W-1:0]        r_lp_y1;
    logic [LP_W-1:0]        n_lp;
    logic [LP_W-1:0]        r_hp_x [HP_DEPTH];
    logic [HP_W-1:0]        r_hp;
    logic [HP_W-1:0]        n_hp;

    function automatic logic [HP_W-1:0] sext_lp(input logic [LP_W-1:0] v);
        return {{(HP_W-LP_W){v[LP_W-1]}}, v};
    endfunction

    // all terms are taken modulo 2^LP_W / 2^HP_W, which gives the wrap
    always_comb begin
        n_lp = (r_lp_y0 << 1) - r_lp_y1 + LP_W'(i_sample)
             - (LP_W'(r_lp_x[LP_TAP_MID]) << 1) + LP_W'(r_lp_x[LP_DEPTH-1]);
        n_hp = r_hp
             + ((sext_lp(r_hp_x[HP_TAP_A]) - sext_lp(r_hp_x[HP_TAP_B])) << HP_FRAC)
             + sext_lp(r_hp_x[HP_DEPTH-1]) - sext_lp(r_lp_y0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LP_DEPTH; i++) r_lp_x[i] <= '0;
            for (int i = 0; i < HP_DEPTH; i++) r_hp_x[i] <= '0;
            r_lp_y0 <= '0;
            r_lp_y1 <= '0;
            r_hp    <= '0;
        end else begin
            if (i_ld.lp) begin
                r_lp_x[0] <= i_sample;
                for (int i = 1; i < LP_DEPTH; i++) r_lp_x[i] <= r_lp_x[i-1];
                r_lp_y1 <= r_lp_y0;
                r_lp_y0 <= n_lp;
            end
            if (i_ld.hp) begin
                r_hp_x[0] <= r_lp_y0;
                for (int i = 1; i < HP_DEPTH; i++) r_hp_x[i] <= r_hp_x[i-1];
                r_hp <= n_hp;
            end
        end
    end

    assign o_hp = r_hp;

endmodule

`default_nettype wire

// File: hdl/qrs_energy.sv
`default_nettype none

module qrs_energy (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire qrs_pkg::t_energy_ld      i_ld,
    input  wire logic [qrs_pkg::HP_W-1:0] i_hp,
    output logic [qrs_pkg::HP_W-1:0]      o_bp,
    output logic [qrs_pkg::VAL_W-1:0]     o_cur
);
    import qrs_pkg::*;

    logic [HP_W-1:0]          r_dv_line [DV_DEPTH];
    logic signed [DV_W-1:0]   r_dv;
    logic signed [DV_W-1:0]   n_dv;
    logic [DV_W-1:0]          w_abs;
    logic [MAG_W-1:0]         w_mag;
    logic [2*MAG_W-1:0]       w_prod;
    logic [2*MAG_W-SQ_SHIFT-1:0] w_shifted;
    logic [VAL_W-1:0]         n_sq;
    logic [VAL_W-1:0]         r_sq;
    logic [HP_W-1:0]          r_sq_bp;
    logic [VAL_W-1:0]         r_sq_line [SQ_LINE_DEPTH];
    logic [WIN_W-1:0]         r_win;
    logic [WIN_W-1:0]         w_sum;
    logic [VAL_W-1:0]         r_cur;
    logic [HP_W-1:0]          r_int_bp;

    function automatic logic signed [DV_W-1:0] sext_hp(input logic [HP_W-1:0] v);
        return $signed({{(DV_W-HP_W){v[HP_W-1]}}, v});
    endfunction

    always_comb begin
        // derivative, exact in DV_W bits
        n_dv = (sext_hp(i_hp) <<< 1) + sext_hp(r_dv_line[0])
             - sext_hp(r_dv_line[2]) - (sext_hp(r_dv_line[3]) <<< 1);
        // square of the magnitude, truncated to Q.8, saturate
        w_abs     = r_dv[DV_W-1] ? DV_W'(-r_dv) : DV_W'(r_dv);
        w_mag     = w_abs[MAG_W-1:0];
        w_prod    = w_mag * w_mag;
        w_shifted = w_prod[2*MAG_W-1:SQ_SHIFT];
        n_sq      = (|w_shifted[2*MAG_W-SQ_SHIFT-1:VAL_W]) ? '1 : w_shifted[VAL_W-1:0];
        // window: newest square plus the running sum of the older ones
        w_sum     = WIN_W'(r_sq) + r_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DV_DEPTH; i++) r_dv_line[i] <= '0;
            for (int i = 0; i < SQ_LINE_DEPTH; i++) r_sq_line[i] <= '0;
            r_win <= '0;
        end else begin
            if (i_ld.dv) begin
                r_dv_line[0] <= i_hp;
                for (int i = 1; i < DV_DEPTH; i++) r_dv_line[i] <= r_dv_line[i-1];
            end
            if (i_ld.integ) begin
                r_sq_line[0] <= r_sq;
                for (int i = 1; i < SQ_LINE_DEPTH; i++) r_sq_line[i] <= r_sq_line[i-1];
                r_win <= w_sum - WIN_W'(r_sq_line[SQ_LINE_DEPTH-1]);
            end
        end
    end

    // stage payload registers
    always_ff @(posedge i_clk) begin
        if (i_ld.dv) begin
            r_dv <= n_dv;
        end
        if (i_ld.sq) begin
            r_sq    <= n_sq;
            r_sq_bp <= r_dv_line[0];
        end
        if (i_ld.integ) begin
            r_cur    <= w_sum[WIN_W-1:INT_SHIFT];
            r_int_bp <= r_sq_bp;
        end
    end

    assign o_bp  = r_int_bp;
    assign o_cur = r_cur;

endmodule

`default_nettype wire

// File: hdl/qrs_threshold.sv
`default_nettype none

module qrs_threshold (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_ld,
    input  wire qrs_pkg::t_cfg_wr          i_cfg,
    input  wire logic [qrs_pkg::VAL_W-1:0] i_cur,
    input  wire logic [qrs_pkg::HP_W-1:0]  i_bp,
    output logic [qrs_pkg::HP_W-1:0]       o_bp,
    output logic [qrs_pkg::VAL_W-1:0]      o_integrated,
    output logic                           o_qrs
);
    import qrs_pkg::*;

    logic [VAL_W-1:0]  r_hist0;
    logic [VAL_W-1:0]  r_hist1;
    logic [VAL_W-1:0]  r_tp;
    logic              r_flag;
    logic [VAL_W-1:0]  r_sig_store   [PEAK_AVG_DEPTH];
    logic [VAL_W-1:0]  r_noise_store [PEAK_AVG_DEPTH];
    logic [PSUM_W-1:0] r_sig_sum;
    logic [PSUM_W-1:0] r_noise_sum;
    logic [VAL_W-1:0]  r_sig_lvl;
    logic [VAL_W-1:0]  r_noise_lvl;
    logic [VAL_W-1:0]  r_thr;
    logic [HP_W-1:0]   r_bp;
    logic [VAL_W-1:0]  r_int;

    logic              w_rise;
    logic [VAL_W-1:0]  w_tp;
    logic              w_above;
    logic              w_close;
    logic              w_peak_sig;
    logic [PSUM_W-1:0] w_sig_sum;
    logic [PSUM_W-1:0] w_noise_sum;
    logic [VAL_W-1:0]  w_sig_lvl;
    logic [VAL_W-1:0]  w_noise_lvl;
    logic [VAL_W-1:0]  w_thr;

    function automatic logic [VAL_W-1:0] thr_mix(input logic [VAL_W-1:0] noise,
                                                 input logic [VAL_W-1:0] sig);
        logic [THR_W-1:0] acc;
        acc = (THR_W'(noise) << 1) + THR_W'(noise) + THR_W'(sig);
        return acc[VAL_W+1:2];
    endfunction

    always_comb begin
        w_rise  = i_cur > r_hist1;
        w_tp    = (w_rise && (i_cur > r_tp)) ? i_cur : r_tp;
        w_above = w_tp > r_thr;
        // a closing fall needs no rise, so the tracked peak is the stored one
        w_close = !w_rise && ({i_cur, 1'b0} < {1'b0, r_tp});
        w_peak_sig  = r_tp > r_thr;
        w_sig_sum   = r_sig_sum + PSUM_W'(r_tp) - PSUM_W'(r_sig_store[PEAK_AVG_DEPTH-1]);
        w_noise_sum = r_noise_sum + PSUM_W'(r_tp)
                    - PSUM_W'(r_noise_store[PEAK_AVG_DEPTH-1]);
        w_sig_lvl   = w_sig_sum[PSUM_W-1:AVG_SHIFT];
        w_noise_lvl = w_noise_sum[PSUM_W-1:AVG_SHIFT];
        w_thr       = w_peak_sig ? thr_mix(r_noise_lvl, w_sig_lvl)
                                 : thr_mix(w_noise_lvl, r_sig_lvl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist0     <= '0;
            r_hist1     <= '0;
            r_tp        <= '0;
            r_flag      <= 1'b0;
            for (int i = 0; i < PEAK_AVG_DEPTH; i++) begin
                r_sig_store[i]   <= '0;
                r_noise_store[i] <= '0;
            end
            r_sig_sum   <= '0;
            r_noise_sum <= '0;
            r_sig_lvl   <= '0;
            r_noise_lvl <= '0;
            r_thr       <= '0;
        end else if (i_ld) begin
            r_hist0 <= i_cur;
            r_hist1 <= r_hist0;
            if (w_close) begin
                r_flag <= 1'b0;
                r_tp   <= '0;
                r_thr  <= w_thr;
                if (w_peak_sig) begin
                    r_sig_store[0] <= r_tp;
                    for (int i = 1; i < PEAK_AVG_DEPTH; i++)
                        r_sig_store[i] <= r_sig_store[i-1];
                    r_sig_sum <= w_sig_sum;
                    r_sig_lvl <= w_sig_lvl;
                end else begin
                    r_noise_store[0] <= r_tp;
                    for (int i = 1; i < PEAK_AVG_DEPTH; i++)
                        r_noise_store[i] <= r_noise_store[i-1];
                    r_noise_sum <= w_noise_sum;
                    r_noise_lvl <= w_noise_lvl;
                end
            end else begin
                r_tp <= w_tp;
                if (w_above) r_flag <= 1'b1;
            end
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_THRESHOLD_INIT:    r_thr       <= i_cfg.data[VAL_W-1:0];
                CFG_SIGNAL_LEVEL_INIT: r_sig_lvl   <= i_cfg.data[VAL_W-1:0];
                CFG_NOISE_LEVEL_INIT:  r_noise_lvl <= i_cfg.data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_bp  <= i_bp;
            r_int <= i_cur;
        end
    end

    assign o_bp         = r_bp;
    assign o_integrated = r_int;
    assign o_qrs        = r_flag;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;
    import qrs_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    // Margin on top of the pipeline depth for a result to reach the outputs.
    localparam int RESULT_LATENCY = NSTAGE + 3;
    localparam int MAX_SHOWN = 40;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;
    // Index 3 lies past the register list: the block must drop the write.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum logic {PEAK_SIGNAL, PEAK_NOISE} t_peak_class;

    typedef struct {
        logic signed [HP_W-1:0] bandpass;
        logic [VAL_W-1:0]       integrated;
        logic                   detected;
    } t_qrs_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [SAMPLE_BITS-1:0]        i_sample = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [HP_W-1:0]        o_bandpass_value;
    logic [VAL_W-1:0]              o_integrated_value;
    logic                          o_qrs_flag;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_idx = '0;
    logic [CFG_W-1:0]              i_cfg_data = '0;

    qrs_detector #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_sample           (i_sample),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_bandpass_value   (o_bandpass_value),
        .o_integrated_value (o_integrated_value),
        .o_qrs_flag         (o_qrs_flag),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the detector state, kept at the block's widths.
    logic [SAMPLE_BITS-1:0]   lp_taps [LP_DEPTH];
    logic signed [LP_W-1:0]   lp_out [2];
    logic signed [LP_W-1:0]   hp_taps [HP_DEPTH];
    logic signed [HP_W-1:0]   hp_last;
    logic signed [HP_W-1:0]   dv_taps [DV_DEPTH];
    logic [VAL_W-1:0]         sq_taps [SQ_LINE_DEPTH];
    logic [VAL_W-1:0]         integ_hist [2];
    logic [VAL_W-1:0]         peak_hold;
    logic                     qrs_flag;
    logic [VAL_W-1:0]         peak_store [2][PEAK_AVG_DEPTH];
    logic [VAL_W-1:0]         signal_lvl;
    logic [VAL_W-1:0]         noise_lvl;
    logic [VAL_W-1:0]         threshold_lvl;

    t_qrs_result pending_results[$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    function automatic bit chance(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // Clear everything the way reset does; registers come back as zero.
    function automatic void clear_detector_state();
        int i;
        foreach (lp_taps[i]) lp_taps[i] = '0;
        foreach (hp_taps[i]) hp_taps[i] = '0;
        foreach (dv_taps[i]) dv_taps[i] = '0;
        foreach (sq_taps[i]) sq_taps[i] = '0;
        for (i = 0; i < PEAK_AVG_DEPTH; i++) begin
            peak_store[PEAK_SIGNAL][i] = '0;
            peak_store[PEAK_NOISE][i] = '0;
        end
        lp_out[0] = '0;
        lp_out[1] = '0;
        integ_hist[0] = '0;
        integ_hist[1] = '0;
        hp_last = '0;
        peak_hold = '0;
        qrs_flag = 1'b0;
        signal_lvl = '0;
        noise_lvl = '0;
        threshold_lvl = '0;
    endfunction

    // Push a closed peak into its store and return the new class average.
    function automatic logic [VAL_W-1:0] push_peak(t_peak_class cls, logic [VAL_W-1:0] pk);
        logic [63:0] total;
        int i;
        for (i = PEAK_AVG_DEPTH - 1; i > 0; i--) peak_store[cls][i] = peak_store[cls][i-1];
        peak_store[cls][0] = pk;
        total = '0;
        for (i = 0; i < PEAK_AVG_DEPTH; i++) total += peak_store[cls][i];
        total = total / PEAK_AVG_DEPTH;
        return total[VAL_W-1:0];
    endfunction

    // Run one sample through the cascade and queue the result it must produce.
    function automatic void predict_qrs_result(logic [SAMPLE_BITS-1:0] x);
        longint lp_sum, hp_sum, dv_sum;
        logic signed [LP_W-1:0] lp;
        logic signed [HP_W-1:0] hp;
        logic [63:0] mag, sq, win, cur64, thr64;
        logic [VAL_W-1:0] cur, old;
        t_qrs_result res;
        int i;

        // low-pass, wraps at its width
        lp_sum = 2 * longint'(lp_out[0]) - longint'(lp_out[1]) + longint'(x)
                 - 2 * longint'(lp_taps[LP_TAP_MID]) + longint'(lp_taps[LP_DEPTH-1]);
        lp = lp_sum[LP_W-1:0];
        for (i = LP_DEPTH - 1; i > 0; i--) lp_taps[i] = lp_taps[i-1];
        lp_taps[0] = x;
        lp_out[1] = lp_out[0];
        lp_out[0] = lp;

        // high-pass in Q.5, wraps at its width
        hp_sum = longint'(hp_last)
                 + 32 * (longint'(hp_taps[HP_TAP_A]) - longint'(hp_taps[HP_TAP_B]))
                 + longint'(hp_taps[HP_DEPTH-1]) - longint'(lp);
        hp = hp_sum[HP_W-1:0];
        for (i = HP_DEPTH - 1; i > 0; i--) hp_taps[i] = hp_taps[i-1];
        hp_taps[0] = lp;
        hp_last = hp;

        // derivative, exact; square truncated to Q.8 and saturated
        dv_sum = 2 * longint'(hp) + longint'(dv_taps[0]) - longint'(dv_taps[2])
                 - 2 * longint'(dv_taps[3]);
        for (i = DV_DEPTH - 1; i > 0; i--) dv_taps[i] = dv_taps[i-1];
        dv_taps[0] = hp;
        mag = (dv_sum < 0) ? -dv_sum : dv_sum;
        sq = (mag * mag) >> SQ_SHIFT;
        if (sq > VAL_MAX) sq = 64'(VAL_MAX);

        // moving window over the newest square and the held ones
        win = sq;
        for (i = 0; i < SQ_LINE_DEPTH; i++) win += sq_taps[i];
        for (i = SQ_LINE_DEPTH - 1; i > 0; i--) sq_taps[i] = sq_taps[i-1];
        sq_taps[0] = sq[VAL_W-1:0];
        win = win >> INT_SHIFT;
        if (win > VAL_MAX) win = 64'(VAL_MAX);
        cur = win[VAL_W-1:0];

        // adaptive threshold: compare against the value two samples back
        old = integ_hist[1];
        integ_hist[1] = integ_hist[0];
        integ_hist[0] = cur;
        cur64 = 64'(cur);
        if (cur > old && cur > peak_hold) peak_hold = cur;
        if (peak_hold > threshold_lvl) qrs_flag = 1'b1;
        if (cur <= old && (cur64 << 1) < peak_hold) begin
            qrs_flag = 1'b0;
            if (peak_hold > threshold_lvl) signal_lvl = push_peak(PEAK_SIGNAL, peak_hold);
            else noise_lvl = push_peak(PEAK_NOISE, peak_hold);
            thr64 = (3 * 64'(noise_lvl) + 64'(signal_lvl)) >> 2;
            threshold_lvl = thr64[VAL_W-1:0];
            peak_hold = '0;
        end

        res.bandpass = hp;
        res.integrated = cur;
        res.detected = qrs_flag;
        pending_results.push_back(res);
    endfunction

    // A register write also reloads the matching live level.
    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        case (idx)
            CFG_THRESHOLD_INIT:    threshold_lvl = value[VAL_W-1:0];
            CFG_SIGNAL_LEVEL_INIT: signal_lvl = value[VAL_W-1:0];
            CFG_NOISE_LEVEL_INIT:  noise_lvl = value[VAL_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_SHOWN) $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Compare every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_qrs_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_bandpass_value !== want.bandpass)
                    report_mismatch($sformatf("bandpass_value got %0d expected %0d",
                                              o_bandpass_value, want.bandpass));
                if (o_integrated_value !== want.integrated)
                    report_mismatch($sformatf("integrated_value got %0d expected %0d",
                                              o_integrated_value, want.integrated));
                if (o_qrs_flag !== want.detected)
                    report_mismatch($sformatf("qrs_flag got %0b expected %0b",
                                              o_qrs_flag, want.detected));
            end
        end
    end

    // Receiver back-pressure, re-rolled every cycle.
    always @(negedge i_clk) begin
        i_stall <= chance(stall_pct);
    end

    // Present one request and hold it until taken. Enter and leave at a
    // falling edge; valid stays up so the next request can follow directly.
    task automatic send_sample(logic [SAMPLE_BITS-1:0] s);
        while (chance(send_idle_pct)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_qrs_result(s);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (RESULT_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        apply_register(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic program_levels(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] sig,
                                  logic [CFG_W-1:0] noi);
        drain_results();
        write_register(CFG_THRESHOLD_INIT, thr);
        write_register(CFG_SIGNAL_LEVEL_INIT, sig);
        write_register(CFG_NOISE_LEVEL_INIT, noi);
    endtask

    // Full-scale steps and swings, plus both checkerboard codes so every
    // sample bit toggles; hard steps push the square toward saturation.
    task automatic test_sample_extremes();
        int i;
        send_sample('0);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        for (i = 0; i < 6; i++) send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        for (i = 0; i < 6; i++) send_sample('0);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(SAMPLE_BITS'(SAMPLE_MAX));
        send_sample('0);
    endtask

    // Load every register at its top value, try an index past the list, then
    // run a short pulse so the reloaded levels and threshold show up.
    task automatic test_register_writes();
        program_levels(VAL_MAX, VAL_MAX, VAL_MAX);
        write_register(CFG_UNUSED_IDX, CFG_W'({$urandom(), $urandom()}));
        send_sample(12'd100);
        send_sample(12'd4000);
        send_sample(12'd4095);
        send_sample(12'd100);
        send_sample(12'd100);
        program_levels('0, '0, '0);
    endtask

    // Beat-shaped trains: quiet baseline, sharp rise and fall. One train in
    // five is replaced by a burst of raw noise to break the pattern.
    task automatic test_beat_train(int n_items);
        int sent, base, amp, rise, gap, i;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(4, 0) == 0) begin
                repeat ($urandom_range(10, 3)) begin
                    send_sample(SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0)));
                    sent++;
                end
            end else begin
                base = $urandom_range(2500, 200);
                amp = $urandom_range(SAMPLE_MAX - base, 300);
                rise = $urandom_range(4, 1);
                gap = $urandom_range(45, 20);
                for (i = 0; i < gap; i++)
                    send_sample(SAMPLE_BITS'(base + $urandom_range(30, 0)));
                for (i = 1; i <= rise; i++) send_sample(SAMPLE_BITS'(base + amp * i / rise));
                for (i = rise - 1; i >= 0; i--) send_sample(SAMPLE_BITS'(base + amp * i / rise));
                sent += gap + 2 * rise;
            end
        end
    endtask

    task automatic test_random_samples(int n_items);
        repeat (n_items) send_sample(SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0)));
    endtask

    // Idling mix per phase: none, sender only, receiver only, both.
    int phase_send_idle [4] = '{0, 49, 0, 29};
    int phase_stall [4] = '{0, 0, 49, 29};

    initial begin
        int p;
        clear_detector_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_sample_extremes();
        test_register_writes();

        for (p = 0; p < 4; p++) begin
            // settle levels at zero, mid, top-threshold and small values
            case (p)
                0: program_levels('0, '0, '0);
                1: program_levels({16'd0, $urandom()}, {16'd0, $urandom()},
                                  {16'd0, $urandom()});
                2: program_levels(VAL_MAX, '0, '0);
                default: program_levels(CFG_W'($urandom_range(1 << 20, 0)),
                                        CFG_W'($urandom_range(1 << 20, 0)),
                                        CFG_W'($urandom_range(1 << 20, 0)));
            endcase
            send_idle_pct = phase_send_idle[p];
            stall_pct = phase_stall[p];
            test_beat_train(75);
            test_random_samples(15);
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("qrs_detector regression: pass");
        end else begin
            $display("qrs_detector regression: fail");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run.
    initial begin
        #400000;
        $display("qrs_detector regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/qrs_pkg.sv
hdl/qrs_filter.sv
hdl/qrs_energy.sv
hdl/qrs_threshold.sv
hdl/qrs_detector.sv
tb/sv/testbench.sv
